### hdl/vtpd_pkg.sv
// ----------------------------------------------------------------------------
// vtpd_pkg
// Shared constants for the vertex transform and perspective divide unit:
// field and register widths, the matrix register count and reset values.
// ----------------------------------------------------------------------------
package vtpd_pkg;

  // payload field and matrix register widths
  localparam int FIELD_W  = 32;
  localparam int REG_W    = 64;
  localparam int NUM_REGS = 8;
  localparam int IDX_W    = 3;
  // pass-through fields: normal x, y, z and texture u, v
  localparam int NUM_PT   = 5;

  typedef logic [REG_W-1:0]   mat_reg_t;
  typedef logic [FIELD_W-1:0] field_t;

  // matrix registers reset to the identity matrix in Q16.16
  localparam mat_reg_t MAT_RESET [NUM_REGS] = '{
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000
  };

endpackage

### hdl/vertex_transform_perspective_divide_unit.sv
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide_unit
// Multiplies a vertex position (x, y, z, 1) by a configured 4x4 fixed point
// matrix and divides x, y, z by the resulting w, with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  in_valid / in_stall carries one vertex per transfer:
//     position, normal and texture coordinates
//   result channel out_valid / out_stall carries one projected vertex per
//     transfer, with w_was_zero and saturated flags
//   cfg_wr_en / cfg_idx / cfg_data write one 64-bit matrix register per
//     cycle; write only while no vertex is in flight
// Throughput: one vertex per clock when the receiver does not stall.
// Path: product register, row-sum register, divider setup stage, then one
//   restoring-divider stage per quotient bit for x, y and z side by side,
//   then the output register.
// Reset: the matrix returns to identity and the pipeline empties.
// Stall: each stage holds while the next one is full and held, so bubbles
//   close up; in_stall rises only once every stage is occupied.
// ----------------------------------------------------------------------------
module vertex_transform_perspective_divide_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [vtpd_pkg::IDX_W-1:0]        cfg_idx,
  input  logic [vtpd_pkg::REG_W-1:0]        cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [vtpd_pkg::FIELD_W-1:0] in_pos_x,
  input  logic signed [vtpd_pkg::FIELD_W-1:0] in_pos_y,
  input  logic signed [vtpd_pkg::FIELD_W-1:0] in_pos_z,
  input  logic signed [vtpd_pkg::FIELD_W-1:0] in_normal_x_in,
  input  logic signed [vtpd_pkg::FIELD_W-1:0] in_normal_y_in,
  input  logic signed [vtpd_pkg::FIELD_W-1:0] in_normal_z_in,
  input  logic signed [vtpd_pkg::FIELD_W-1:0] in_tex_u_in,
  input  logic signed [vtpd_pkg::FIELD_W-1:0] in_tex_v_in,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [vtpd_pkg::FIELD_W-1:0] out_proj_x,
  output logic signed [vtpd_pkg::FIELD_W-1:0] out_proj_y,
  output logic signed [vtpd_pkg::FIELD_W-1:0] out_proj_z,
  output logic signed [vtpd_pkg::FIELD_W-1:0] out_normal_x_out,
  output logic signed [vtpd_pkg::FIELD_W-1:0] out_normal_y_out,
  output logic signed [vtpd_pkg::FIELD_W-1:0] out_normal_z_out,
  output logic signed [vtpd_pkg::FIELD_W-1:0] out_tex_u_out,
  output logic signed [vtpd_pkg::FIELD_W-1:0] out_tex_v_out,
  output logic                              out_w_was_zero,
  output logic                              out_saturated
);

  localparam int CW   = COORD_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int PW   = 2 * CW;
  localparam int SW   = PW - FB + 2;
  localparam int AW   = SW + FB;
  localparam int OW   = SW + CW - FB;
  localparam int NDIV = CW;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] sum_t;
  typedef logic [SW-1:0]        mag_t;
  typedef logic [CW-1:0]        quo_t;
  typedef logic [vtpd_pkg::NUM_PT-1:0][vtpd_pkg::FIELD_W-1:0] pt_t;

  // matrix registers
  vtpd_pkg::mat_reg_t mat_r [vtpd_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vtpd_pkg::NUM_REGS; i++) begin
        mat_r[i] <= vtpd_pkg::MAT_RESET[i];
      end
    end else if (cfg_wr_en) begin
      mat_r[cfg_idx] <= cfg_data;
    end
  end

  // matrix entries, low bits of each half
  coord_t m [4][4];

  always_comb begin
    vtpd_pkg::mat_reg_t rv;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        rv = mat_r[vtpd_pkg::IDX_W'(r * 2 + c / 2)];
        m[r][c] = (c % 2 == 1) ? rv[CW-1:0] : rv[32+CW-1:32];
      end
    end
  end

  // handshake: per-stage ready chain, bubbles collapse
  logic        v1_r, v2_r, out_valid_r;
  logic        vd_r  [NDIV+1];
  logic        rdy_out, rdy1, rdy2;
  logic        rdy_d [NDIV+1];

  always_comb begin
    rdy_out = !out_valid_r || !out_stall;
    rdy_d[NDIV] = !vd_r[NDIV] || rdy_out;
    for (int k = NDIV - 1; k >= 0; k--) begin
      rdy_d[k] = !vd_r[k] || rdy_d[k+1];
    end
    rdy2 = !v2_r || rdy_d[0];
    rdy1 = !v1_r || rdy2;
  end

  assign in_stall = !rdy1;

  // stage 1: twelve products
  coord_t p [3];
  prod_t  prod_nxt [4][3];
  prod_t  prod_r   [4][3];
  coord_t off_r    [4];
  pt_t    pt_in, pt1_r, pt2_r;

  assign p[0]  = in_pos_x[CW-1:0];
  assign p[1]  = in_pos_y[CW-1:0];
  assign p[2]  = in_pos_z[CW-1:0];
  assign pt_in = {in_tex_v_in, in_tex_u_in, in_normal_z_in, in_normal_y_in, in_normal_x_in};

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r][c] = m[r][c] * p[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      prod_r <= prod_nxt;
      for (int r = 0; r < 4; r++) begin
        off_r[r] <= m[r][3];
      end
      pt1_r <= pt_in;
    end
  end

  // stage 2: floor to fraction bits and sum each row
  sum_t sum_nxt [4];
  sum_t sum_r   [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_nxt[r] = SW'(off_r[r]) + SW'(prod_r[r][0] >>> FB)
                 + SW'(prod_r[r][1] >>> FB) + SW'(prod_r[r][2] >>> FB);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      sum_r <= sum_nxt;
      pt2_r <= pt1_r;
    end
  end

  // divider stage state; index 0 is the setup stage
  mag_t   drem_r [NDIV+1][3];
  quo_t   dnq_r  [NDIV+1][3];
  logic   dneg_r [NDIV+1][3];
  logic   dovf_r [NDIV+1][3];
  quo_t   dclv_r [NDIV+1][3];
  logic   dcls_r [NDIV+1][3];
  mag_t   db_r   [NDIV+1];
  logic   dwz_r  [NDIV+1];
  pt_t    dpt_r  [NDIV+1];

  mag_t   drem_nxt [1:NDIV][3];
  quo_t   dnq_nxt  [1:NDIV][3];

  // setup: magnitudes, overflow check, clamp for zero w
  mag_t   bmag;
  mag_t   amag    [3];
  mag_t   drem_s  [3];
  quo_t   dnq_s   [3];
  logic   ovf_s   [3];
  quo_t   clv_s   [3];
  logic   cls_s   [3];
  logic   neg_s   [3];

  always_comb begin
    logic [AW-1:0] anum;
    logic          inrange;
    bmag = sum_r[3][SW-1] ? mag_t'(-sum_r[3]) : mag_t'(sum_r[3]);
    for (int i = 0; i < 3; i++) begin
      amag[i]   = sum_r[i][SW-1] ? mag_t'(-sum_r[i]) : mag_t'(sum_r[i]);
      anum      = AW'(amag[i]) << FB;
      drem_s[i] = SW'(anum >> CW);
      dnq_s[i]  = anum[CW-1:0];
      ovf_s[i] = OW'(amag[i]) >= (OW'(bmag) << (CW - FB));
      neg_s[i] = sum_r[i][SW-1] ^ sum_r[3][SW-1];
      inrange  = (sum_r[i][SW-1:CW-1] == '0) || (sum_r[i][SW-1:CW-1] == '1);
      cls_s[i] = !inrange;
      clv_s[i] = inrange ? sum_r[i][CW-1:0]
                         : {sum_r[i][SW-1], {(CW-1){~sum_r[i][SW-1]}}};
    end
  end

  // divide steps: one quotient bit per stage per lane
  always_comb begin
    logic [SW:0] trial;
    logic [SW:0] diff;
    logic        ge;
    for (int k = 1; k <= NDIV; k++) begin
      for (int i = 0; i < 3; i++) begin
        trial = {drem_r[k-1][i], dnq_r[k-1][i][CW-1]};
        diff  = trial - {1'b0, db_r[k-1]};
        ge    = !diff[SW];
        drem_nxt[k][i] = ge ? diff[SW-1:0] : trial[SW-1:0];
        dnq_nxt[k][i]  = {dnq_r[k-1][i][CW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NDIV; k++) begin
        vd_r[k] <= 1'b0;
      end
    end else begin
      if (rdy_d[0]) begin
        vd_r[0] <= v2_r;
      end
      for (int k = 1; k <= NDIV; k++) begin
        if (rdy_d[k]) begin
          vd_r[k] <= vd_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d[0]) begin
      for (int i = 0; i < 3; i++) begin
        drem_r[0][i] <= drem_s[i];
        dnq_r[0][i]  <= dnq_s[i];
        dneg_r[0][i] <= neg_s[i];
        dovf_r[0][i] <= ovf_s[i];
        dclv_r[0][i] <= clv_s[i];
        dcls_r[0][i] <= cls_s[i];
      end
      db_r[0]  <= bmag;
      dwz_r[0] <= (sum_r[3] == '0);
      dpt_r[0] <= pt2_r;
    end
    for (int k = 1; k <= NDIV; k++) begin
      if (rdy_d[k]) begin
        for (int i = 0; i < 3; i++) begin
          drem_r[k][i] <= drem_nxt[k][i];
          dnq_r[k][i]  <= dnq_nxt[k][i];
          dneg_r[k][i] <= dneg_r[k-1][i];
          dovf_r[k][i] <= dovf_r[k-1][i];
          dclv_r[k][i] <= dclv_r[k-1][i];
          dcls_r[k][i] <= dcls_r[k-1][i];
        end
        db_r[k]  <= db_r[k-1];
        dwz_r[k] <= dwz_r[k-1];
        dpt_r[k] <= dpt_r[k-1];
      end
    end
  end

  // final: clamp quotient, apply sign, pick zero-w path
  coord_t res_f [3];
  logic   sat_f;

  always_comb begin
    quo_t limit;
    quo_t mag;
    logic big;
    sat_f = 1'b0;
    for (int i = 0; i < 3; i++) begin
      limit = dneg_r[NDIV][i] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      big   = dovf_r[NDIV][i] || (dnq_r[NDIV][i] > limit);
      mag   = big ? limit : dnq_r[NDIV][i];
      if (dwz_r[NDIV]) begin
        res_f[i] = dclv_r[NDIV][i];
        sat_f    = sat_f | dcls_r[NDIV][i];
      end else begin
        res_f[i] = dneg_r[NDIV][i] ? -mag : mag;
        sat_f    = sat_f | big;
      end
    end
  end

  // output register
  coord_t res_r [3];
  pt_t    pto_r;
  logic   wz_o_r, sat_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= vd_r[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      res_r   <= res_f;
      pto_r   <= dpt_r[NDIV];
      wz_o_r  <= dwz_r[NDIV];
      sat_o_r <= sat_f;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_proj_x       = vtpd_pkg::FIELD_W'(res_r[0]);
  assign out_proj_y       = vtpd_pkg::FIELD_W'(res_r[1]);
  assign out_proj_z       = vtpd_pkg::FIELD_W'(res_r[2]);
  assign out_normal_x_out = pto_r[0];
  assign out_normal_y_out = pto_r[1];
  assign out_normal_z_out = pto_r[2];
  assign out_tex_u_out    = pto_r[3];
  assign out_tex_v_out    = pto_r[4];
  assign out_w_was_zero   = wz_o_r;
  assign out_saturated    = sat_o_r;

  // an empty output register means every stage can move
  a_empty_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled while result register empty");

  // a result taken frees the whole chain
  a_taken_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall) |-> !in_stall)
    else $error("input stalled while result transfer completes");

  // x lane partial remainder stays below the divisor when no overflow and w nonzero
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (vd_r[NDIV] && !dovf_r[NDIV][0] && !dwz_r[NDIV]) |-> (drem_r[NDIV][0] < db_r[NDIV]))
    else $error("divider remainder out of range");

endmodule
